[hdl/ahtok_pkg.sv]
package ahtok_pkg;

    // Result kind codes.
    typedef enum logic [2:0] {
        KIND_IGNORE   = 3'd0,
        KIND_KEY      = 3'd1,
        KIND_VALUE    = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_ERROR    = 3'd4
    } kind_t;

    // Authentication scheme codes.
    typedef enum logic [1:0] {
        METHOD_NONE   = 2'd0,
        METHOD_BASIC  = 2'd1,
        METHOD_DIGEST = 2'd2
    } method_t;

    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [2:0] DIGEST_LAST_POS = 3'd6;
    localparam logic [2:0] BASIC_LAST_POS  = 3'd5;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_letter;
        logic       is_upper;
        logic       is_eq;
        logic       is_quote;
        logic       is_bslash;
        logic       is_comma;
        logic       is_space;
    } byte_class_t;

    // Expected byte of "Digest " at a prefix position.
    function automatic logic [7:0] digest_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h44;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h67;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h74;
            3'd6:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "Basic " at a prefix position.
    function automatic logic [7:0] basic_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h42;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h63;
            3'd5:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/ahtok_if.sv]
interface ahtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ahtok_out_if;
    import ahtok_pkg::*;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] char_out;
    method_t    method;
    logic       line_done;
    logic       line_ok;

    modport source (output valid, output kind, output char_out, output method,
                    output line_done, output line_ok, input ready);
    modport sink   (input valid, input kind, input char_out, input method,
                    input line_done, input line_ok, output ready);
endinterface

[hdl/ahtok_front.sv]
module ahtok_front (
    ahtok_in_if.sink               line_bytes,
    input  logic                   q_ready,
    output logic                   push,
    output ahtok_pkg::byte_class_t item
);
    import ahtok_pkg::*;

    logic is_upper;
    logic is_lower;

    // Decode the byte classes once here so the parser tests flags, not byte ranges.
    assign is_upper = (line_bytes.ch >= 8'h41) && (line_bytes.ch <= 8'h5A);
    assign is_lower = (line_bytes.ch >= 8'h61) && (line_bytes.ch <= 8'h7A);

    assign line_bytes.ready = q_ready;
    assign push             = line_bytes.valid && q_ready;

    always_comb
    begin
        item.ch        = line_bytes.ch;
        item.last      = line_bytes.last;
        item.is_letter = is_upper || is_lower;
        item.is_upper  = is_upper;
        item.is_eq     = (line_bytes.ch == CH_EQ);
        item.is_quote  = (line_bytes.ch == CH_QUOTE);
        item.is_bslash = (line_bytes.ch == CH_BSLASH);
        item.is_comma  = (line_bytes.ch == CH_COMMA);
        item.is_space  = (line_bytes.ch == CH_SPACE);
    end

endmodule

[hdl/ahtok_queue.sv]
module ahtok_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ahtok_pkg::byte_class_t push_item,
    output logic                   ready,
    input  logic                   pop,
    output logic                   valid,
    output ahtok_pkg::byte_class_t head
);
    import ahtok_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    byte_class_t      mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/ahtok_back.sv]
module ahtok_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  ahtok_pkg::byte_class_t q_item,
    output logic                   pop,
    ahtok_out_if.source            tokens
);
    import ahtok_pkg::*;

    typedef enum logic [1:0] {
        STAGE_KEY   = 2'd0,
        STAGE_BEGIN = 2'd1,
        STAGE_VALUE = 2'd2,
        STAGE_SEP   = 2'd3
    } stage_t;

    logic [2:0] prefix_pos_reg, prefix_pos_next;
    logic [1:0] match_flags_reg, match_flags_next;
    method_t    scheme_reg, scheme_next;
    stage_t     stage_reg, stage_next;
    logic       escape_reg, escape_next;
    logic       comma_reg, comma_next;
    logic       error_reg, error_next;

    logic       out_valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    method_t    method_reg;
    logic       done_reg;
    logic       ok_reg, ok_next;

    logic       digest_ok;
    logic       basic_ok;
    logic [1:0] flags_upd;
    kind_t      key_kind;
    logic [7:0] key_char;

    assign pop = q_valid && (!out_valid_reg || tokens.ready);

    assign tokens.valid     = out_valid_reg;
    assign tokens.kind      = kind_reg;
    assign tokens.char_out  = char_reg;
    assign tokens.method    = method_reg;
    assign tokens.line_done = done_reg;
    assign tokens.line_ok   = ok_reg;

    // Prefix matching: only the first letter may be lower case.
    assign digest_ok = (prefix_pos_reg != 3'd7)
                       && ((q_item.ch == digest_char(prefix_pos_reg))
                           || (prefix_pos_reg == 3'd0 && q_item.ch == CH_LOWER_D));
    assign basic_ok  = (prefix_pos_reg < 3'd6)
                       && ((q_item.ch == basic_char(prefix_pos_reg))
                           || (prefix_pos_reg == 3'd0 && q_item.ch == CH_LOWER_B));
    assign flags_upd = {match_flags_reg[1] && basic_ok, match_flags_reg[0] && digest_ok};

    // Classification of a byte taken as part of a key.
    always_comb
    begin
        if (q_item.is_letter)
        begin
            key_kind = KIND_KEY;
        end
        else if (q_item.is_eq)
        begin
            key_kind = KIND_IGNORE;
        end
        else
        begin
            key_kind = KIND_ERROR;
        end
        key_char = q_item.is_upper ? (q_item.ch | CASE_BIT) : q_item.ch;
    end

    always_comb
    begin
        prefix_pos_next  = prefix_pos_reg;
        match_flags_next = match_flags_reg;
        scheme_next      = scheme_reg;
        stage_next       = stage_reg;
        escape_next      = escape_reg;
        comma_next       = comma_reg;
        error_next       = error_reg;
        kind_next        = KIND_IGNORE;
        char_next        = 8'h00;

        if (!error_reg)
        begin
            if (scheme_reg == METHOD_NONE)
            begin
                match_flags_next = flags_upd;
                if (flags_upd == 2'b00)
                begin
                    kind_next = KIND_ERROR;
                end
                else
                begin
                    if (flags_upd[0] && prefix_pos_reg == DIGEST_LAST_POS)
                    begin
                        scheme_next = METHOD_DIGEST;
                    end
                    else if (flags_upd[1] && prefix_pos_reg == BASIC_LAST_POS)
                    begin
                        scheme_next = METHOD_BASIC;
                    end
                    prefix_pos_next = prefix_pos_reg + 3'd1;
                end
            end
            else
            begin
                case (stage_reg)
                    STAGE_KEY:
                    begin
                        kind_next = key_kind;
                        char_next = key_char;
                        if (q_item.is_eq)
                        begin
                            stage_next = STAGE_BEGIN;
                        end
                    end
                    STAGE_BEGIN:
                    begin
                        if (q_item.is_quote)
                        begin
                            stage_next = STAGE_VALUE;
                        end
                        else
                        begin
                            kind_next = KIND_ERROR;
                        end
                    end
                    STAGE_VALUE:
                    begin
                        if (escape_reg)
                        begin
                            if (q_item.is_quote)
                            begin
                                escape_next = 1'b0;
                                kind_next   = KIND_VALUE;
                                char_next   = q_item.ch;
                            end
                            else
                            begin
                                kind_next = KIND_ERROR;
                            end
                        end
                        else if (q_item.is_bslash)
                        begin
                            escape_next = 1'b1;
                        end
                        else if (q_item.is_quote)
                        begin
                            stage_next = STAGE_SEP;
                            kind_next  = KIND_PAIR_END;
                        end
                        else
                        begin
                            kind_next = KIND_VALUE;
                            char_next = q_item.ch;
                        end
                    end
                    default:
                    begin
                        if (comma_reg)
                        begin
                            // After the comma, the first non-space byte opens a key.
                            if (!q_item.is_space)
                            begin
                                comma_next = 1'b0;
                                kind_next  = key_kind;
                                char_next  = key_char;
                                stage_next = q_item.is_eq ? STAGE_BEGIN : STAGE_KEY;
                            end
                        end
                        else if (q_item.is_comma)
                        begin
                            comma_next = 1'b1;
                        end
                        else if (!q_item.is_space)
                        begin
                            kind_next = KIND_ERROR;
                        end
                    end
                endcase
            end
            if (kind_next == KIND_ERROR)
            begin
                error_next = 1'b1;
            end
        end

        if (kind_next != KIND_KEY && kind_next != KIND_VALUE)
        begin
            char_next = 8'h00;
        end

        ok_next = q_item.last && (scheme_next != METHOD_NONE) && !error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_pos_reg  <= 3'd0;
            match_flags_reg <= 2'b11;
            scheme_reg      <= METHOD_NONE;
            stage_reg       <= STAGE_KEY;
            escape_reg      <= 1'b0;
            comma_reg       <= 1'b0;
            error_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (q_item.last)
                begin
                    prefix_pos_reg  <= 3'd0;
                    match_flags_reg <= 2'b11;
                    scheme_reg      <= METHOD_NONE;
                    stage_reg       <= STAGE_KEY;
                    escape_reg      <= 1'b0;
                    comma_reg       <= 1'b0;
                    error_reg       <= 1'b0;
                end
                else
                begin
                    prefix_pos_reg  <= prefix_pos_next;
                    match_flags_reg <= match_flags_next;
                    scheme_reg      <= scheme_next;
                    stage_reg       <= stage_next;
                    escape_reg      <= escape_next;
                    comma_reg       <= comma_next;
                    error_reg       <= error_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (tokens.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= kind_next;
            char_reg   <= char_next;
            method_reg <= scheme_next;
            done_reg   <= q_item.last;
            ok_reg     <= ok_next;
        end
    end

    a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.last |=> prefix_pos_reg == 3'd0 && !error_reg
                               && scheme_reg == METHOD_NONE && stage_reg == STAGE_KEY)
        else $error("parser state not cleared after line end");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !q_item.last && kind_next == KIND_ERROR |=> error_reg)
        else $error("error not recorded");

    a_char_only_for_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_KEY && kind_reg != KIND_VALUE |-> char_reg == 8'h00)
        else $error("char_out nonzero on a non-data result");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |-> done_reg && method_reg != METHOD_NONE)
        else $error("line_ok without line end or scheme");

    a_escape_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> stage_reg == STAGE_VALUE)
        else $error("escape pending outside a value");

endmodule

[hdl/auth_header_param_tokenizer_top.sv]
// HTTP authentication header tokenizer. Bytes of one header line arrive on
// line_bytes, one per transfer, with last marking the final byte. The block
// matches the scheme prefix "Digest " or "Basic " (only the first letter may
// be lower case), then splits key="value" pairs and returns exactly one
// result per byte on tokens: its kind (ignored, key char, value char, pair
// end or error), the lower-cased key char or the value char, the scheme
// known so far, and on the last byte line_done with line_ok. After an error
// every byte up to the end of the line is reported as ignored, and an
// unfinished final pair is dropped silently. While tokens is ready, the block
// sustains one byte per clock: a classifier feeds a small queue of
// QUEUE_DEPTH entries, and the parser drains one entry per cycle into an
// output register when that one is empty or being taken. Bytes are held in
// the queue, results in the output register; input flows while a result
// waits until the queue is full. The parser's state update sets that rate.
module auth_header_param_tokenizer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    ahtok_in_if.sink    line_bytes,
    ahtok_out_if.source tokens
);
    import ahtok_pkg::*;

    logic        q_ready;
    logic        push;
    byte_class_t push_item;
    logic        q_valid;
    logic        pop;
    byte_class_t head;

    // Front end: decode each byte into class flags and push it.
    ahtok_front u_front (
        .line_bytes (line_bytes),
        .q_ready    (q_ready),
        .push       (push),
        .item       (push_item)
    );

    // Queue decoupling the front end from the parser.
    ahtok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (q_ready),
        .pop       (pop),
        .valid     (q_valid),
        .head      (head)
    );

    // Back end: prefix match, pair tokenizing and the result register.
    ahtok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (head),
        .pop     (pop),
        .tokens  (tokens)
    );

endmodule
